// File: sv/cro_pkg.sv
// Package for the octant circle rasterizer: widths, codes and helpers.
// No dependencies; every other file in the project imports it.
`default_nettype none

package cro_pkg;

  // Coordinate width of center and edge points
  localparam int COORD_BITS = 10;

  // Fixed field widths of the channels
  localparam int FIELD_W = 10;
  localparam int PIX_W   = 13;
  localparam int CFG_W   = 11;

  // Derived datapath widths
  localparam int COL_W      = COORD_BITS + 1;        // column, radius-sized values
  localparam int R2_W       = 2 * COORD_BITS + 1;    // squared radius
  localparam int SQ_W       = 2 * COORD_BITS + 2;    // square accumulator
  localparam int RAD_W      = 2 * COORD_BITS + 4;    // radicand shifter, even width
  localparam int ROOT_W     = COORD_BITS + 2;        // raw root bits
  localparam int REM_W      = COORD_BITS + 5;        // partial remainder
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int CNT_W      = $clog2(COORD_BITS + 2);
  localparam int EXT_W      = (COORD_BITS + 3 > PIX_W) ? COORD_BITS + 3 : PIX_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_DIM_RESET    = 11'd600;

  // Opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Take the low COORD_BITS bits of a field, zero-extending when wider
  function automatic logic [COORD_BITS-1:0] coord_mask(input logic [FIELD_W-1:0] v);
    logic [COORD_BITS+FIELD_W-1:0] t;
    t = {{COORD_BITS{1'b0}}, v};
    return t[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/cro_if.sv
// Valid/ready channel interfaces for the octant circle rasterizer.
// Depends on cro_pkg for field widths.
`default_nettype none

interface cro_in_if
  import cro_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [FIELD_W-1:0] center_x;
  logic [FIELD_W-1:0] center_y;
  logic [FIELD_W-1:0] edge_x;
  logic [FIELD_W-1:0] edge_y;

  modport source (output valid, opcode, center_x, center_y, edge_x, edge_y,
                  input ready);
  modport sink   (input valid, opcode, center_x, center_y, edge_x, edge_y,
                  output ready);
endinterface

interface cro_out_if
  import cro_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic                    in_bounds;
  logic                    last_of_step;
  logic                    circle_done;

  modport source (output valid, pixel_x, pixel_y, in_bounds, last_of_step, circle_done,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, in_bounds, last_of_step, circle_done,
                  output ready);
endinterface

`default_nettype wire

// File: sv/circle_rasterizer_octant.sv
// Octant circle rasterizer top level: bit-serial squarer, digit-serial
// square root and eight-way pixel emitter. Depends on cro_pkg and cro_if.
//
//  channel  | dir | handshake          | carries
//  ---------+-----+--------------------+-------------------------------------------
//  in_ch    | in  | valid/ready        | opcode, center_x/y, edge_x/y
//  out_ch   | out | valid/ready        | pixel_x/y, in_bounds, last_of_step, circle_done
//  cfg_*    | in  | write enable only  | image_width (0), image_height (1)
//
// A start item holds the input while it is accepted, squared in two squarer
// passes, the second accumulating onto the first, and then rooted. A step
// item is accepted, squared once, rooted and sent out as eight pixels, and
// also waits while out_ch.ready holds off a waiting pixel before the eighth
// one. One shift-add squarer and one two-bit-per-cycle root unit do the
// arithmetic. One item is in work at a time; the output register holds a
// pixel while out_ch.ready is low and the emitter waits. rst_n is synchronous.
`default_nettype none

module circle_rasterizer_octant
  import cro_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  cro_in_if.sink              in_ch,
  cro_out_if.source           out_ch,
  input  wire                 cfg_wr_en,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_EMIT
  } state_t;

  state_t state_r;

  // Configuration and circle state
  logic [CFG_W-1:0]      width_r, height_r;
  logic [COORD_BITS-1:0] mid_x_r, mid_y_r, ay_r;
  logic [R2_W-1:0]       r2_r;
  logic [COL_W-1:0]      column_r, last_column_r, y_r;
  logic                  active_r, start_r, pass2_r, done_r;

  // Serial datapath registers
  logic [SQ_W-1:0]   acc_r, mcand_r;
  logic [COL_W-1:0]  mplier_r;
  logic [RAD_W-1:0]  rad_sh_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [2:0]        k_r;

  // Output register
  logic                    out_valid_r;
  logic signed [PIX_W-1:0] pixel_x_r, pixel_y_r;
  logic                    in_bounds_r, last_r, circle_done_r;

  // Input decode for a start item
  logic [COORD_BITS-1:0] cx, cy, ex, ey, ax, ay;
  always_comb begin
    cx = coord_mask(in_ch.center_x);
    cy = coord_mask(in_ch.center_y);
    ex = coord_mask(in_ch.edge_x);
    ey = coord_mask(in_ch.edge_y);
    ax = (ex > cx) ? ex - cx : cx - ex;
    ay = (ey > cy) ? ey - cy : cy - ey;
  end

  logic in_acc;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Shift-add squarer step and radicand for the step path
  logic [SQ_W-1:0] acc_nxt;
  logic [R2_W-1:0] rad;
  always_comb begin
    acc_nxt = mplier_r[0] ? acc_r + mcand_r : acc_r;
    if (acc_nxt > {1'b0, r2_r}) begin
      rad = '0;
    end else begin
      rad = r2_r - acc_nxt[R2_W-1:0];
    end
  end

  // Root recurrence: two radicand bits in, one root bit out
  logic [REM_W-1:0]  rem_sh, trial, rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic [ROOT_W:0]   root_p1;
  logic [COL_W-1:0]  rounded;
  logic              ge;
  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], rad_sh_r[RAD_W-1 -: 2]};
    trial    = {{(REM_W-ROOT_W-2){1'b0}}, root_r, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? rem_sh - trial : rem_sh;
    root_nxt = {root_r[ROOT_W-2:0], ge};
    root_p1  = {1'b0, root_nxt} + 1'b1;
    rounded  = root_p1[COL_W:1];
  end

  // Mirror the current column/row pair into pixel k
  logic [COL_W-1:0]        a_x, a_y;
  logic signed [EXT_W-1:0] mx_s, my_s, ax_s, ay_s, px_full, py_full, w_s, h_s;
  logic                    pix_in;
  always_comb begin
    a_x     = k_r[2] ? y_r : column_r;
    a_y     = k_r[2] ? column_r : y_r;
    mx_s    = $signed({{(EXT_W-COORD_BITS){1'b0}}, mid_x_r});
    my_s    = $signed({{(EXT_W-COORD_BITS){1'b0}}, mid_y_r});
    ax_s    = $signed({{(EXT_W-COL_W){1'b0}}, a_x});
    ay_s    = $signed({{(EXT_W-COL_W){1'b0}}, a_y});
    px_full = k_r[0] ? mx_s - ax_s : mx_s + ax_s;
    py_full = k_r[1] ? my_s - ay_s : my_s + ay_s;
    w_s     = $signed({{(EXT_W-CFG_W){1'b0}}, width_r});
    h_s     = $signed({{(EXT_W-CFG_W){1'b0}}, height_r});
    pix_in  = !px_full[EXT_W-1] && !py_full[EXT_W-1] && (px_full < w_s) && (py_full < h_s);
  end

  logic emit_go;
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_DIM_RESET;
      height_r <= CFG_DIM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer, serial datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mid_x_r       <= '0;
      mid_y_r       <= '0;
      r2_r          <= '0;
      column_r      <= '0;
      last_column_r <= '0;
      active_r      <= 1'b0;
      start_r       <= 1'b0;
      pass2_r       <= 1'b0;
      cnt_r         <= '0;
      k_r           <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // Drop the output item once taken
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_ch.opcode == OP_START) begin
            mid_x_r  <= cx;
            mid_y_r  <= cy;
            ay_r     <= ay;
            mcand_r  <= {{(SQ_W-COORD_BITS){1'b0}}, ax};
            mplier_r <= {{(COL_W-COORD_BITS){1'b0}}, ax};
            acc_r    <= '0;
            cnt_r    <= '0;
            start_r  <= 1'b1;
            pass2_r  <= 1'b0;
            state_r  <= ST_MUL;
          end else if (in_acc && active_r) begin
            mcand_r  <= {{(SQ_W-COL_W){1'b0}}, column_r};
            mplier_r <= column_r;
            acc_r    <= '0;
            cnt_r    <= '0;
            start_r  <= 1'b0;
            state_r  <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc_r    <= acc_nxt;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(COL_W - 1)) begin
            cnt_r <= '0;
            if (start_r && !pass2_r) begin
              // second square accumulates onto the first
              mcand_r  <= {{(SQ_W-COORD_BITS){1'b0}}, ay_r};
              mplier_r <= {{(COL_W-COORD_BITS){1'b0}}, ay_r};
              pass2_r  <= 1'b1;
            end else begin
              rem_r   <= '0;
              root_r  <= '0;
              state_r <= ST_SQRT;
              if (start_r) begin
                r2_r     <= acc_nxt[R2_W-1:0];
                rad_sh_r <= {2'b00, acc_nxt[R2_W-1:0], 1'b0};
              end else begin
                rad_sh_r <= {1'b0, rad, 2'b00};
              end
            end
          end
        end
        ST_SQRT: begin
          rem_r    <= rem_nxt;
          root_r   <= root_nxt;
          rad_sh_r <= rad_sh_r << 2;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
            cnt_r <= '0;
            if (start_r) begin
              last_column_r <= rounded;
              column_r      <= '0;
              active_r      <= 1'b1;
              state_r       <= ST_IDLE;
            end else begin
              y_r     <= rounded;
              done_r  <= (column_r >= last_column_r);
              k_r     <= '0;
              state_r <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid_r   <= 1'b1;
            pixel_x_r     <= px_full[PIX_W-1:0];
            pixel_y_r     <= py_full[PIX_W-1:0];
            in_bounds_r   <= pix_in;
            last_r        <= (k_r == 3'd7);
            circle_done_r <= (k_r == 3'd7) && done_r;
            k_r           <= k_r + 1'b1;
            if (k_r == 3'd7) begin
              // advance the column or close the circle
              if (done_r) begin
                active_r <= 1'b0;
              end else begin
                column_r <= column_r + 1'b1;
              end
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = pixel_x_r;
  assign out_ch.pixel_y      = pixel_y_r;
  assign out_ch.in_bounds    = in_bounds_r;
  assign out_ch.last_of_step = last_r;
  assign out_ch.circle_done  = circle_done_r;

`ifndef SYNTHESIS
  a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> active_r)
    else $error("emitting pixels with no circle in progress");

  a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (column_r <= last_column_r))
    else $error("column ran past the last column");

  a_k_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_EMIT) |-> (k_r == 3'd0))
    else $error("pixel index not back at zero outside emit");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.circle_done) |-> out_ch.last_of_step)
    else $error("circle done flagged on a pixel that is not last of its step");
`endif

endmodule

`default_nettype wire
